// ===== sv/pca_pkg.sv =====
// Shared types, codes and helpers of the page chain allocator.
`timescale 1ns / 1ps
`default_nettype none

package pca_pkg;

    localparam int PAGE_W        = 8;
    localparam int COUNT_W       = 9;
    localparam int MAX_LIVE      = 256;
    localparam int DEF_NUM_PAGES = 256;

    localparam logic [PAGE_W-1:0] RESET_BASE  = 8'd4;
    localparam logic [PAGE_W-1:0] MIN_BASE    = 8'd2;
    localparam logic [PAGE_W-1:0] PG_UNUSED   = 8'd0;
    localparam logic [PAGE_W-1:0] PG_RESERVED = 8'd1;

    localparam logic [2:0] OP_FORMAT = 3'd0;
    localparam logic [2:0] OP_ALLOC  = 3'd1;
    localparam logic [2:0] OP_READ   = 3'd2;
    localparam logic [2:0] OP_WALK   = 3'd3;
    localparam logic [2:0] OP_COUNT  = 3'd4;
    localparam logic [2:0] OP_FREE   = 3'd5;

    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_BADARG = 2'd1;
    localparam logic [1:0] ST_NOFREE = 2'd2;
    localparam logic [1:0] ST_BROKEN = 2'd3;

    // one request to the page table per cycle: an optional write and a read address
    typedef struct packed {
        logic              we;
        logic [PAGE_W-1:0] waddr;
        logic [PAGE_W-1:0] wdata;
        logic [PAGE_W-1:0] raddr;
    } mem_req_t;

    // v is a data page: base <= v < live
    function automatic logic is_data(
        input logic [PAGE_W-1:0]  v,
        input logic [PAGE_W-1:0]  base,
        input logic [COUNT_W-1:0] live
    );
        return (v >= base) && ({1'b0, v} < live);
    endfunction

endpackage

`default_nettype wire

// ===== sv/pca_table.sv =====
// Page table memory: one write port, one read port with registered data.
`timescale 1ns / 1ps
`default_nettype none

module pca_table #(
    parameter int NUM_PAGES = pca_pkg::DEF_NUM_PAGES
) (
    input  wire logic                      clk,
    input  wire pca_pkg::mem_req_t         req,
    output logic [pca_pkg::PAGE_W-1:0]     rd_data
);
    import pca_pkg::*;

    localparam int LIVE = (NUM_PAGES < MAX_LIVE) ? NUM_PAGES : MAX_LIVE;
    localparam int AW   = $clog2(LIVE);

    logic [PAGE_W-1:0] mem [LIVE];
    logic [PAGE_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (req.we)
        begin
            mem[req.waddr[AW-1:0]] <= req.wdata;
        end
        rd_data_reg <= mem[req.raddr[AW-1:0]];
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

// ===== sv/pca_ctrl.sv =====
// Sequencer: format sweep, first-fit scan, entry read, chain walk/count/free, result register.
`timescale 1ns / 1ps
`default_nettype none

module pca_ctrl #(
    parameter int NUM_PAGES = pca_pkg::DEF_NUM_PAGES
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic [pca_pkg::PAGE_W-1:0] data_base,
    input  wire logic                       in_valid,
    output logic                            in_ready,
    input  wire logic [2:0]                 opcode,
    input  wire logic [pca_pkg::PAGE_W-1:0] page,
    input  wire logic [pca_pkg::PAGE_W-1:0] hops,
    output logic                            out_valid,
    input  wire logic                       out_ready,
    output logic [1:0]                      status,
    output logic [pca_pkg::PAGE_W-1:0]      page_out,
    output logic [pca_pkg::COUNT_W-1:0]     chain_pages,
    output pca_pkg::mem_req_t               req,
    input  wire logic [pca_pkg::PAGE_W-1:0] rd_data
);
    import pca_pkg::*;

    localparam int LIVE = (NUM_PAGES < MAX_LIVE) ? NUM_PAGES : MAX_LIVE;
    localparam logic [COUNT_W-1:0] LIVE_N = COUNT_W'(LIVE);

    typedef enum logic [3:0] {
        S_INIT, S_IDLE, S_FMT, S_ACHK, S_SCAN, S_LINK, S_RDN, S_WALK, S_CHAIN, S_OUT
    } state_t;

    state_t               state_reg, state_next;
    logic [2:0]           op_reg, op_next;
    logic [PAGE_W-1:0]    pg_reg, pg_next;
    logic [PAGE_W-1:0]    hops_reg, hops_next;
    logic [PAGE_W-1:0]    cur_reg, cur_next;
    logic [COUNT_W-1:0]   idx_reg, idx_next;
    logic [COUNT_W-1:0]   cnt_reg, cnt_next;
    logic [1:0]           res_st_reg, res_st_next;
    logic [PAGE_W-1:0]    res_pg_reg, res_pg_next;
    logic [COUNT_W-1:0]   res_cnt_reg, res_cnt_next;
    logic                 out_valid_reg, out_valid_next;
    logic [1:0]           status_reg, status_next;
    logic [PAGE_W-1:0]    page_out_reg, page_out_next;
    logic [COUNT_W-1:0]   chain_pages_reg, chain_pages_next;

    logic [PAGE_W-1:0]    base;
    logic [PAGE_W-1:0]    fmt_base;
    logic                 region_empty;
    logic [COUNT_W-1:0]   cnt_inc;

    assign base         = (data_base < MIN_BASE) ? MIN_BASE : data_base;
    assign fmt_base     = (state_reg == S_INIT) ? RESET_BASE : base;
    assign region_empty = ({1'b0, base} >= LIVE_N);
    assign cnt_inc      = cnt_reg + 9'd1;

    assign in_ready    = (state_reg == S_IDLE);
    assign out_valid   = out_valid_reg;
    assign status      = status_reg;
    assign page_out    = page_out_reg;
    assign chain_pages = chain_pages_reg;

    always_comb
    begin
        state_next       = state_reg;
        op_next          = op_reg;
        pg_next          = pg_reg;
        hops_next        = hops_reg;
        cur_next         = cur_reg;
        idx_next         = idx_reg;
        cnt_next         = cnt_reg;
        res_st_next      = res_st_reg;
        res_pg_next      = res_pg_reg;
        res_cnt_next     = res_cnt_reg;
        out_valid_next   = out_valid_reg;
        status_next      = status_reg;
        page_out_next    = page_out_reg;
        chain_pages_next = chain_pages_reg;
        req              = '0;
        req.raddr        = cur_reg;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_INIT, S_FMT:
            begin
                req.we    = 1'b1;
                req.waddr = idx_reg[PAGE_W-1:0];
                req.wdata = (idx_reg < {1'b0, fmt_base}) ? PG_RESERVED : PG_UNUSED;
                idx_next  = idx_reg + 9'd1;
                if (idx_reg == LIVE_N - 9'd1)
                begin
                    if (state_reg == S_INIT)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        res_st_next  = ST_OK;
                        res_pg_next  = PG_UNUSED;
                        res_cnt_next = '0;
                        state_next   = S_OUT;
                    end
                end
            end

            S_IDLE:
            begin
                if (in_valid)
                begin
                    op_next      = opcode;
                    pg_next      = page;
                    hops_next    = hops;
                    cur_next     = page;
                    idx_next     = '0;
                    cnt_next     = '0;
                    res_st_next  = ST_BADARG;
                    res_pg_next  = PG_UNUSED;
                    res_cnt_next = '0;
                    state_next   = S_OUT;
                    req.raddr    = page;
                    unique case (opcode)
                        OP_FORMAT:
                        begin
                            state_next = S_FMT;
                        end
                        OP_ALLOC:
                        begin
                            if (page == PG_UNUSED)
                            begin
                                if (region_empty)
                                begin
                                    res_st_next = ST_NOFREE;
                                end
                                else
                                begin
                                    req.raddr  = base;
                                    idx_next   = {1'b0, base};
                                    state_next = S_SCAN;
                                end
                            end
                            else if (is_data(page, base, LIVE_N))
                            begin
                                state_next = S_ACHK;
                            end
                        end
                        OP_READ:
                        begin
                            if ({1'b0, page} < LIVE_N)
                            begin
                                state_next = S_RDN;
                            end
                        end
                        OP_WALK:
                        begin
                            if (is_data(page, base, LIVE_N))
                            begin
                                state_next = S_WALK;
                            end
                        end
                        OP_COUNT, OP_FREE:
                        begin
                            if (is_data(page, base, LIVE_N))
                            begin
                                state_next = S_CHAIN;
                            end
                        end
                        default:
                        begin
                            state_next = S_OUT;
                        end
                    endcase
                end
            end

            S_ACHK:
            begin
                // previous page must end its chain
                if (rd_data != pg_reg)
                begin
                    res_st_next = ST_BADARG;
                    state_next  = S_OUT;
                end
                else if (region_empty)
                begin
                    res_st_next = ST_NOFREE;
                    state_next  = S_OUT;
                end
                else
                begin
                    req.raddr  = base;
                    idx_next   = {1'b0, base};
                    state_next = S_SCAN;
                end
            end

            S_SCAN:
            begin
                if (rd_data == PG_UNUSED)
                begin
                    req.we    = 1'b1;
                    req.waddr = idx_reg[PAGE_W-1:0];
                    req.wdata = idx_reg[PAGE_W-1:0];
                    if (pg_reg != PG_UNUSED)
                    begin
                        state_next = S_LINK;
                    end
                    else
                    begin
                        res_st_next = ST_OK;
                        res_pg_next = idx_reg[PAGE_W-1:0];
                        state_next  = S_OUT;
                    end
                end
                else if (idx_reg == LIVE_N - 9'd1)
                begin
                    res_st_next = ST_NOFREE;
                    state_next  = S_OUT;
                end
                else
                begin
                    idx_next  = idx_reg + 9'd1;
                    req.raddr = idx_next[PAGE_W-1:0];
                end
            end

            S_LINK:
            begin
                req.we      = 1'b1;
                req.waddr   = pg_reg;
                req.wdata   = idx_reg[PAGE_W-1:0];
                res_st_next = ST_OK;
                res_pg_next = idx_reg[PAGE_W-1:0];
                state_next  = S_OUT;
            end

            S_RDN:
            begin
                res_st_next = ST_OK;
                res_pg_next = rd_data;
                state_next  = S_OUT;
            end

            S_WALK:
            begin
                if (!is_data(rd_data, base, LIVE_N))
                begin
                    res_st_next = ST_BROKEN;
                    res_pg_next = cur_reg;
                    state_next  = S_OUT;
                end
                else if (hops_reg == '0)
                begin
                    res_st_next = ST_OK;
                    res_pg_next = cur_reg;
                    state_next  = S_OUT;
                end
                else
                begin
                    cur_next  = rd_data;
                    hops_next = hops_reg - 8'd1;
                    req.raddr = rd_data;
                end
            end

            S_CHAIN:
            begin
                if (!is_data(rd_data, base, LIVE_N))
                begin
                    res_st_next  = ST_BROKEN;
                    res_pg_next  = cur_reg;
                    res_cnt_next = cnt_reg;
                    state_next   = S_OUT;
                end
                else
                begin
                    if (op_reg == OP_FREE)
                    begin
                        req.we    = 1'b1;
                        req.waddr = cur_reg;
                        req.wdata = PG_UNUSED;
                    end
                    cnt_next     = cnt_inc;
                    res_cnt_next = cnt_inc;
                    if (rd_data == cur_reg)
                    begin
                        res_st_next = ST_OK;
                        res_pg_next = cur_reg;
                        state_next  = S_OUT;
                    end
                    else if (cnt_inc == LIVE_N)
                    begin
                        // no chain end within the table size
                        res_st_next = ST_BROKEN;
                        res_pg_next = rd_data;
                        state_next  = S_OUT;
                    end
                    else
                    begin
                        cur_next  = rd_data;
                        req.raddr = rd_data;
                    end
                end
            end

            S_OUT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next   = 1'b1;
                    status_next      = res_st_reg;
                    page_out_next    = res_pg_reg;
                    chain_pages_next = res_cnt_reg;
                    state_next       = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_INIT;
            op_reg          <= OP_FORMAT;
            pg_reg          <= '0;
            hops_reg        <= '0;
            cur_reg         <= '0;
            idx_reg         <= '0;
            cnt_reg         <= '0;
            res_st_reg      <= ST_OK;
            res_pg_reg      <= '0;
            res_cnt_reg     <= '0;
            out_valid_reg   <= 1'b0;
            status_reg      <= ST_OK;
            page_out_reg    <= '0;
            chain_pages_reg <= '0;
        end
        else
        begin
            state_reg       <= state_next;
            op_reg          <= op_next;
            pg_reg          <= pg_next;
            hops_reg        <= hops_next;
            cur_reg         <= cur_next;
            idx_reg         <= idx_next;
            cnt_reg         <= cnt_next;
            res_st_reg      <= res_st_next;
            res_pg_reg      <= res_pg_next;
            res_cnt_reg     <= res_cnt_next;
            out_valid_reg   <= out_valid_next;
            status_reg      <= status_next;
            page_out_reg    <= page_out_next;
            chain_pages_reg <= chain_pages_next;
        end
    end

endmodule

`default_nettype wire

// ===== sv/page_chain_allocator.sv =====
// Page chain allocator: one table entry per cycle through a one-read, one-write page table.
// The page table holds LIVE = min(NUM_PAGES, 256) entries.
// One item at a time; the next item is taken once the result is in the output register.
// The single table read per cycle sets the rate of scans and chain traversals.
// After reset a sweep formats the table for base 4; in_ready stays low until the sweep ends.
`timescale 1ns / 1ps
`default_nettype none

module page_chain_allocator #(
    parameter int NUM_PAGES = pca_pkg::DEF_NUM_PAGES
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        cfg_wr_en,
    input  wire logic [pca_pkg::PAGE_W-1:0]  cfg_wr_data,
    input  wire logic                        in_valid,
    output logic                             in_ready,
    input  wire logic [2:0]                  opcode,
    input  wire logic [pca_pkg::PAGE_W-1:0]  page,
    input  wire logic [pca_pkg::PAGE_W-1:0]  hops,
    output logic                             out_valid,
    input  wire logic                        out_ready,
    output logic [1:0]                       status,
    output logic [pca_pkg::PAGE_W-1:0]       page_out,
    output logic [pca_pkg::COUNT_W-1:0]      chain_pages
);
    import pca_pkg::*;

    logic [PAGE_W-1:0] data_base_reg;
    mem_req_t          req;
    logic [PAGE_W-1:0] rd_data;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            data_base_reg <= RESET_BASE;
        end
        else if (cfg_wr_en)
        begin
            data_base_reg <= cfg_wr_data;
        end
    end

    pca_ctrl #(
        .NUM_PAGES (NUM_PAGES)
    ) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .data_base   (data_base_reg),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .opcode      (opcode),
        .page        (page),
        .hops        (hops),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .status      (status),
        .page_out    (page_out),
        .chain_pages (chain_pages),
        .req         (req),
        .rd_data     (rd_data)
    );

    pca_table #(
        .NUM_PAGES (NUM_PAGES)
    ) u_table (
        .clk     (clk),
        .req     (req),
        .rd_data (rd_data)
    );

endmodule

`default_nettype wire
